FILE: rtl/core/sal_pkg.sv
// sal_pkg: shared types and constants for the sorted array list.
// Used by sal_cell and sorted_array_list; no dependencies.
package sal_pkg;

  localparam int DATA_W       = 32;
  localparam int IDX_W        = 6;
  localparam int OUT_CNT_W    = 7;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_AT  = 2'd1,
    OP_REMOVE_VAL = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell does in the current cycle
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2,
    CM_DROP   = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t              mode;
    logic [DATA_W-1:0]       value;
    logic [IDX_W-1:0]        idx;
  } cell_ctl_t;

endpackage

FILE: rtl/core/sal_cell.sv
// sal_cell: one entry of the sorted list, with its compare and shift logic.
// Depends on sal_pkg.
module sal_cell import sal_pkg::*; #(
  parameter int POS   = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]  count,
  input  logic [DATA_W-1:0] prev_data,
  input  logic              prev_gt,
  input  logic              prev_ge,
  input  logic [DATA_W-1:0] next_data,
  output logic [DATA_W-1:0] data_o,
  output logic              gt_o,
  output logic              ge_o,
  output logic              hit_o,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              valid;
  logic              sel;

  assign valid = POS < int'(count);
  assign sel   = int'(ctl.idx) == POS;
  assign gt_o  = valid && ($signed(data_r) > $signed(ctl.value));
  assign ge_o  = valid && ($signed(data_r) >= $signed(ctl.value));
  // first cell not below the value, and equal to it
  assign hit_o = ge_o && !prev_ge && (data_r == ctl.value);
  assign data_o = data_r;
  assign rd_o   = data_r & {DATA_W{sel}};

  always_comb begin
    data_nxt = data_r;
    case (ctl.mode)
      CM_INSERT: begin
        if (!valid || gt_o) begin
          data_nxt = prev_gt ? prev_data : ctl.value;
        end
      end
      CM_REMOVE: begin
        if (int'(ctl.idx) <= POS) begin
          data_nxt = next_data;
        end
      end
      CM_DROP: begin
        if (ge_o) begin
          data_nxt = next_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: rtl/core/sorted_array_list.sv
// Sorted list of up to CAPACITY signed 32-bit values in ascending order, held in a
// row of cells that compare and shift in parallel. Insert and remove-at-index leave
// the sequencer idle, so the next word may follow as soon as the output slot is free.
// Remove-value registers the value, deletes one copy a cycle while a match remains,
// then gives its result once the output slot is free. Read registers the index and
// gathers the selected cell through a registered OR tree of eight-cell groups.
// Every request gives one result word with the count and status.
// sorted_array_list: top level, control sequencer and chain of sal_cell.
// Depends on sal_pkg and sal_cell.
module sorted_array_list import sal_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], index[37:32], zero pad
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_data[31:0], entry_count[38:32],
                                  // removed_count[45:39], status[47:46]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + 7) / 8;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DROP  = 4'b0010,
    S_READ  = 4'b0100,
    S_RDOUT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_rdata_r, out_rdata_nxt;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [OUT_CNT_W-1:0] out_rem_r, out_rem_nxt;
  status_t           out_status_r, out_status_nxt;

  logic [DATA_W-1:0] grp_r [NGRP];
  logic [DATA_W-1:0] grp_nxt [NGRP];
  logic [DATA_W-1:0] rd_all;

  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cdata [CAPACITY];
  logic [DATA_W-1:0] crd   [CAPACITY];
  logic [CAPACITY-1:0] cgt, cge, chit;
  logic              hit_any;

  logic              slot_free;
  logic              acc;
  op_t               in_func;
  logic [DATA_W-1:0] in_value;
  logic [IDX_W-1:0]  in_index;
  logic              in_range;

  logic              emit;
  status_t           e_status;
  logic [DATA_W-1:0] e_rdata;
  logic [CNT_W-1:0]  e_rem;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext, rem_ext;

  assign in_func   = op_t'(in_tuser);
  assign in_value  = in_tdata[31:0];
  assign in_index  = in_tdata[37:32];
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign acc       = in_tvalid && in_tready;
  assign in_range  = int'(in_index) < int'(count_r);
  assign hit_any   = |chit;

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] p_data, n_data;
    logic              p_gt, p_ge;
    if (g == 0) begin : g_first
      assign p_data = '0;
      assign p_gt   = 1'b0;
      assign p_ge   = 1'b0;
    end else begin : g_mid
      assign p_data = cdata[g-1];
      assign p_gt   = cgt[g-1];
      assign p_ge   = cge[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign n_data = cdata[g];
    end else begin : g_inner
      assign n_data = cdata[g+1];
    end
    sal_cell #(
      .POS   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .prev_data (p_data),
      .prev_gt   (p_gt),
      .prev_ge   (p_ge),
      .next_data (n_data),
      .data_o    (cdata[g]),
      .gt_o      (cgt[g]),
      .ge_o      (cge[g]),
      .hit_o     (chit[g]),
      .rd_o      (crd[g])
    );
  end

  // read gather: eight-cell groups, registered, then final OR
  always_comb begin
    for (int k = 0; k < NGRP; k++) begin
      grp_nxt[k] = '0;
      for (int j = 0; j < 8; j++) begin
        if (k * 8 + j < CAPACITY) begin
          grp_nxt[k] = grp_nxt[k] | crd[k*8+j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NGRP; k++) begin
      grp_r[k] <= grp_nxt[k];
    end
  end

  always_comb begin
    rd_all = '0;
    for (int k = 0; k < NGRP; k++) begin
      rd_all = rd_all | grp_r[k];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    emit          = 1'b0;
    e_status      = ST_OK;
    e_rdata       = '0;
    e_rem         = '0;
    ctl.mode      = CM_HOLD;
    ctl.value     = (state_r == S_IDLE) ? in_value : val_r;
    ctl.idx       = (state_r == S_IDLE) ? in_index : idx_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_func)
            OP_INSERT: begin
              emit = 1'b1;
              if (int'(count_r) < CAPACITY) begin
                ctl.mode  = CM_INSERT;
                count_nxt = count_r + 1'b1;
              end else begin
                e_status = ST_FULL;
              end
            end
            OP_REMOVE_AT: begin
              emit = 1'b1;
              if (in_range) begin
                ctl.mode  = CM_REMOVE;
                count_nxt = count_r - 1'b1;
                e_rem     = CNT_W'(1);
              end else begin
                e_status = ST_RANGE;
              end
            end
            OP_REMOVE_VAL: begin
              val_nxt   = in_value;
              rem_nxt   = '0;
              state_nxt = S_DROP;
            end
            OP_READ: begin
              if (in_range) begin
                idx_nxt   = in_index;
                state_nxt = S_READ;
              end else begin
                emit     = 1'b1;
                e_status = ST_RANGE;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_DROP: begin
        if (hit_any) begin
          ctl.mode  = CM_DROP;
          count_nxt = count_r - 1'b1;
          rem_nxt   = rem_r + 1'b1;
        end else if (slot_free) begin
          emit      = 1'b1;
          e_rem     = rem_r;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_RDOUT;
      end
      S_RDOUT: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_rdata   = rd_all;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cnt_ext = {{OUT_CNT_W{1'b0}}, count_nxt};
  assign rem_ext = {{OUT_CNT_W{1'b0}}, e_rem};

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_rdata_nxt  = out_rdata_r;
    out_cnt_nxt    = out_cnt_r;
    out_rem_nxt    = out_rem_r;
    out_status_nxt = out_status_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_rdata_nxt  = e_rdata;
      out_cnt_nxt    = cnt_ext[OUT_CNT_W-1:0];
      out_rem_nxt    = rem_ext[OUT_CNT_W-1:0];
      out_status_nxt = e_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_rem_r    <= out_rem_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_status_r, out_rem_r, out_cnt_r, out_rdata_r};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= CAPACITY)
    else $error("fill count above capacity");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE)
    else $error("input ready outside idle");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_status == ST_FULL) |-> int'(count_r) == CAPACITY)
    else $error("full reported below capacity");

  a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DROP && hit_any) |=> count_r == $past(count_r) - 1'b1)
    else $error("drop step did not shrink the list");

endmodule
